// File: sv/tlu_pkg.sv
// Shared types, constants and helpers of the tridiagonal LU factor step.
package tlu_pkg;

   localparam int MulWidth = 32;
   localparam int AccWidth = 66;
   localparam int LambdaFrac = 30;

   typedef struct packed {
      logic               first_row;
      logic signed [31:0] lambda;
      logic [63:0]        diag_offset;
      logic [63:0]        diag_scale;
      logic [63:0]        upper_offset;
      logic [63:0]        upper_scale;
      logic [63:0]        lower_offset;
      logic [63:0]        lower_scale;
   } req_type;

   typedef struct packed {
      logic [63:0] lower_factor;
      logic [63:0] pivot;
      logic [63:0] upper_entry;
      logic        zero_divisor;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9,
      ST_M10, ST_M11, ST_M12, ST_DIV_GO, ST_DIV_WAIT, ST_U0, ST_U1, ST_U2, ST_U3,
      ST_U4, ST_FIN
   } tlu_state_type;

   typedef enum logic [1:0] {
      D_IDLE, D_RUN, D_DONE
   } tlu_div_state_type;

   // Shift right by sh with rounding to nearest, ties away from zero.
   function automatic logic signed [AccWidth-1:0] round_away(
      input logic signed [AccWidth-1:0] x, input int sh);
      logic [AccWidth-1:0] mag;
      logic [AccWidth-1:0] m;
      mag = x[AccWidth-1] ? AccWidth'(-x) : AccWidth'(x);
      m = (mag + (AccWidth'(1) << (sh - 1))) >> sh;
      return x[AccWidth-1] ? signed'(-m) : signed'(m);
   endfunction

endpackage

// File: sv/tlu_front.sv
// Input queue that accepts rows and holds them until the sequencer takes them.
module tlu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  tlu_pkg::req_type req_data,
   output logic             row_valid,
   input  logic             row_take,
   output tlu_pkg::req_type row_data
);
   import tlu_pkg::*;

   req_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push_ok;
   logic       take_ok;

   assign req_full  = (count_ff == 2'd2);
   assign row_valid = (count_ff != 2'd0);
   assign row_data  = mem_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign take_ok   = row_take && row_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_ok) wr_ptr_ff <= !wr_ptr_ff;
         if (take_ok) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push_ok) - 2'(take_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ptr_ff] <= req_data;
   end

`ifndef ASSERT_OFF
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !take_ok) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue count did not follow an accepted transaction");
`endif
endmodule

// File: sv/tlu_div.sv
// Two restoring dividers that form the real and imaginary quotients in parallel.
module tlu_div #(
   parameter int HALF_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [tlu_pkg::AccWidth-1:0]   num_re,
   input  logic signed [tlu_pkg::AccWidth-1:0]   num_im,
   input  logic [2*HALF_WIDTH-1:0]               den,
   output logic                                  done,
   output logic signed [HALF_WIDTH-1:0]          q_re,
   output logic signed [HALF_WIDTH-1:0]          q_im
);
   import tlu_pkg::*;

   localparam int DW = 2 * HALF_WIDTH;
   localparam int FB = HALF_WIDTH / 2;
   localparam int IB = HALF_WIDTH - FB;
   localparam int CW = $clog2(HALF_WIDTH + 1);
   localparam logic signed [HALF_WIDTH-1:0] QMAX = {1'b0, {(HALF_WIDTH-1){1'b1}}};
   localparam logic signed [HALF_WIDTH-1:0] QMIN = {1'b1, {(HALF_WIDTH-1){1'b0}}};

   tlu_div_state_type state_ff, state_in;
   logic [CW-1:0]         cnt_ff;
   logic [DW-1:0]         den_ff;
   logic [DW-1:0]         rem_ff  [2];
   logic [IB-1:0]         sreg_ff [2];
   logic [HALF_WIDTH:0]   q_ff    [2];
   logic                  neg_ff  [2];
   logic                  ovf_ff  [2];
   logic signed [HALF_WIDTH-1:0] res [2];

   always_ff @(posedge clock) begin
      if (reset) state_ff <= D_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      unique case (state_ff)
         D_IDLE: if (start) state_in = D_RUN;
         D_RUN:  if (cnt_ff == '0) state_in = D_DONE;
         D_DONE: begin
            done     = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      logic signed [AccWidth-1:0] n;
      logic [DW-1:0]              mag;
      logic [DW:0]                rs;
      if (state_ff == D_IDLE && start) begin
         den_ff <= den;
         cnt_ff <= CW'(HALF_WIDTH);
         for (int i = 0; i < 2; i++) begin
            n = (i == 0) ? num_re : num_im;
            mag = n[AccWidth-1] ? DW'(-n) : DW'(n);
            neg_ff[i]  <= n[AccWidth-1];
            ovf_ff[i]  <= ((DW+IB)'(mag) >= ((DW+IB)'(den) << IB));
            rem_ff[i]  <= mag >> IB;
            sreg_ff[i] <= mag[IB-1:0];
            q_ff[i]    <= '0;
         end
      end else if (state_ff == D_RUN) begin
         cnt_ff <= cnt_ff - CW'(1);
         for (int i = 0; i < 2; i++) begin
            rs = {rem_ff[i], sreg_ff[i][IB-1]};
            sreg_ff[i] <= sreg_ff[i] << 1;
            if (rs >= {1'b0, den_ff}) begin
               rem_ff[i] <= DW'(rs - {1'b0, den_ff});
               q_ff[i]   <= {q_ff[i][HALF_WIDTH-1:0], 1'b1};
            end else begin
               rem_ff[i] <= DW'(rs);
               q_ff[i]   <= {q_ff[i][HALF_WIDTH-1:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      logic [HALF_WIDTH+1:0] qp;
      logic [HALF_WIDTH:0]   qr;
      for (int i = 0; i < 2; i++) begin
         qp = (HALF_WIDTH+2)'(q_ff[i]) + (HALF_WIDTH+2)'(1);
         qr = qp[HALF_WIDTH+1:1];
         if (ovf_ff[i] || qr[HALF_WIDTH] || qr[HALF_WIDTH-1])
            res[i] = neg_ff[i] ? QMIN : QMAX;
         else if (neg_ff[i])
            res[i] = signed'(-qr[HALF_WIDTH-1:0]);
         else
            res[i] = signed'(qr[HALF_WIDTH-1:0]);
      end
   end

   assign q_re = res[0];
   assign q_im = res[1];
endmodule

// File: sv/tlu_back.sv
// Sequencer and shared multiplier that carry out one row of the factorization.
module tlu_back #(
   parameter int HALF_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             row_valid,
   output logic             row_take,
   input  tlu_pkg::req_type row_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output tlu_pkg::rsp_type rsp_data
);
   import tlu_pkg::*;

   localparam int H  = HALF_WIDTH;
   localparam int FB = H / 2;
   localparam int DW = 2 * H;
   localparam logic signed [AccWidth-1:0] HMAX = {{(AccWidth-H+1){1'b0}}, {(H-1){1'b1}}};
   localparam logic signed [AccWidth-1:0] HMIN = ~HMAX;
   localparam logic signed [H-1:0] SMAX = {1'b0, {(H-1){1'b1}}};
   localparam logic signed [H-1:0] SMIN = {1'b1, {(H-1){1'b0}}};

   function automatic logic signed [H-1:0] hre(input logic [63:0] x);
      return signed'(x[2*H-1:H]);
   endfunction

   function automatic logic signed [H-1:0] him(input logic [63:0] x);
      return signed'(x[H-1:0]);
   endfunction

   function automatic logic signed [H-1:0] sat(input logic signed [AccWidth-1:0] v);
      if (v > HMAX) return SMAX;
      if (v < HMIN) return SMIN;
      return v[H-1:0];
   endfunction

   function automatic logic [63:0] pack(input logic signed [H-1:0] re,
                                        input logic signed [H-1:0] im);
      return 64'({re, im});
   endfunction

   tlu_state_type state_ff, state_in;
   req_type                    item_ff;
   logic signed [63:0]         prod_ff;
   logic signed [AccWidth-1:0] acc_ff;
   logic signed [AccWidth-1:0] num_re_ff, num_im_ff;
   logic [DW-1:0]              den_ff;
   logic signed [H-1:0] diag_re_ff, diag_im_ff, up_re_ff, up_im_ff, low_re_ff, low_im_ff;
   logic signed [H-1:0] lr_ff, li_ff, piv_re_ff, piv_im_ff;
   logic signed [H-1:0] prev_piv_re_ff, prev_piv_im_ff, prev_up_re_ff, prev_up_im_ff;
   logic                zflag_ff;
   rsp_type             out_ff;
   logic                out_valid_ff;

   logic signed [MulWidth-1:0] mul_a, mul_b;
   logic signed [AccWidth-1:0] prod_ext, aff, t_sum, t_dif;
   logic                       prev_zero;
   logic                       div_start, div_done, load_out;
   logic signed [H-1:0]        q_re, q_im;

   assign prod_ext  = AccWidth'(prod_ff);
   assign prev_zero = (prev_piv_re_ff == '0) && (prev_piv_im_ff == '0);
   assign t_sum     = acc_ff + prod_ext;
   assign t_dif     = acc_ff - prod_ext;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic signed [H-1:0] off;
      unique case (state_ff)
         ST_M1:   off = hre(item_ff.diag_offset);
         ST_M2:   off = him(item_ff.diag_offset);
         ST_M3:   off = hre(item_ff.upper_offset);
         ST_M4:   off = him(item_ff.upper_offset);
         ST_M5:   off = hre(item_ff.lower_offset);
         default: off = him(item_ff.lower_offset);
      endcase
      aff = round_away(prod_ext, LambdaFrac) + AccWidth'(off);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      row_take  = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: if (row_valid) begin
            row_take = 1'b1;
            state_in = ST_M0;
         end
         ST_M0: begin
            mul_a = MulWidth'(hre(item_ff.diag_scale));  mul_b = item_ff.lambda;
            state_in = ST_M1;
         end
         ST_M1: begin
            mul_a = MulWidth'(him(item_ff.diag_scale));  mul_b = item_ff.lambda;
            state_in = ST_M2;
         end
         ST_M2: begin
            mul_a = MulWidth'(hre(item_ff.upper_scale)); mul_b = item_ff.lambda;
            state_in = ST_M3;
         end
         ST_M3: begin
            mul_a = MulWidth'(him(item_ff.upper_scale)); mul_b = item_ff.lambda;
            state_in = ST_M4;
         end
         ST_M4: begin
            mul_a = MulWidth'(hre(item_ff.lower_scale)); mul_b = item_ff.lambda;
            state_in = ST_M5;
         end
         ST_M5: begin
            mul_a = MulWidth'(him(item_ff.lower_scale)); mul_b = item_ff.lambda;
            state_in = ST_M6;
         end
         ST_M6: begin
            mul_a = MulWidth'(low_re_ff); mul_b = MulWidth'(prev_piv_re_ff);
            state_in = ST_M7;
         end
         ST_M7: begin
            mul_a = MulWidth'(low_im_ff); mul_b = MulWidth'(prev_piv_im_ff);
            state_in = ST_M8;
         end
         ST_M8: begin
            mul_a = MulWidth'(low_im_ff); mul_b = MulWidth'(prev_piv_re_ff);
            state_in = ST_M9;
         end
         ST_M9: begin
            mul_a = MulWidth'(low_re_ff); mul_b = MulWidth'(prev_piv_im_ff);
            state_in = ST_M10;
         end
         ST_M10: begin
            mul_a = MulWidth'(prev_piv_re_ff); mul_b = MulWidth'(prev_piv_re_ff);
            state_in = ST_M11;
         end
         ST_M11: begin
            mul_a = MulWidth'(prev_piv_im_ff); mul_b = MulWidth'(prev_piv_im_ff);
            state_in = ST_M12;
         end
         ST_M12: begin
            if (item_ff.first_row) state_in = ST_FIN;
            else if (prev_zero)    state_in = ST_U0;
            else                   state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: if (div_done) state_in = ST_U0;
         ST_U0: begin
            mul_a = MulWidth'(lr_ff); mul_b = MulWidth'(prev_up_re_ff);
            state_in = ST_U1;
         end
         ST_U1: begin
            mul_a = MulWidth'(li_ff); mul_b = MulWidth'(prev_up_im_ff);
            state_in = ST_U2;
         end
         ST_U2: begin
            mul_a = MulWidth'(lr_ff); mul_b = MulWidth'(prev_up_im_ff);
            state_in = ST_U3;
         end
         ST_U3: begin
            mul_a = MulWidth'(li_ff); mul_b = MulWidth'(prev_up_re_ff);
            state_in = ST_U4;
         end
         ST_U4: state_in = ST_FIN;
         ST_FIN: if (!out_valid_ff || rsp_pop) begin
            load_out = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath registers; each state consumes the product issued one state earlier.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (row_take) item_ff <= row_data;
      case (state_ff)
         ST_M1:  diag_re_ff <= sat(aff);
         ST_M2:  diag_im_ff <= sat(aff);
         ST_M3:  up_re_ff   <= sat(aff);
         ST_M4:  up_im_ff   <= sat(aff);
         ST_M5:  low_re_ff  <= sat(aff);
         ST_M6:  low_im_ff  <= sat(aff);
         ST_M7:  acc_ff     <= prod_ext;
         ST_M8:  num_re_ff  <= t_sum;
         ST_M9:  acc_ff     <= prod_ext;
         ST_M10: num_im_ff  <= t_dif;
         ST_M11: acc_ff     <= prod_ext;
         ST_M12: begin
            den_ff <= DW'(t_sum);
            if (item_ff.first_row) begin
               lr_ff     <= '0;
               li_ff     <= '0;
               zflag_ff  <= 1'b0;
               piv_re_ff <= diag_re_ff;
               piv_im_ff <= diag_im_ff;
            end else if (prev_zero) begin
               lr_ff    <= low_re_ff[H-1] ? SMIN : SMAX;
               li_ff    <= low_im_ff[H-1] ? SMIN : SMAX;
               zflag_ff <= 1'b1;
            end else begin
               zflag_ff <= 1'b0;
            end
         end
         ST_DIV_WAIT: if (div_done) begin
            lr_ff <= q_re;
            li_ff <= q_im;
         end
         ST_U1: acc_ff <= prod_ext;
         ST_U2: piv_re_ff <= sat(AccWidth'(diag_re_ff) - round_away(t_dif, FB));
         ST_U3: acc_ff <= prod_ext;
         ST_U4: piv_im_ff <= sat(AccWidth'(diag_im_ff) - round_away(t_sum, FB));
         default: ;
      endcase
      if (load_out) begin
         out_ff.lower_factor <= pack(lr_ff, li_ff);
         out_ff.pivot        <= pack(piv_re_ff, piv_im_ff);
         out_ff.upper_entry  <= pack(up_re_ff, up_im_ff);
         out_ff.zero_divisor <= zflag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         prev_piv_re_ff <= '0;
         prev_piv_im_ff <= '0;
         prev_up_re_ff  <= '0;
         prev_up_im_ff  <= '0;
      end else begin
         if (load_out)     out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
         if (load_out) begin
            prev_piv_re_ff <= piv_re_ff;
            prev_piv_im_ff <= piv_im_ff;
            prev_up_re_ff  <= up_re_ff;
            prev_up_im_ff  <= up_im_ff;
         end
      end
   end

   tlu_div #(.HALF_WIDTH(HALF_WIDTH)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_re (num_re_ff),
      .num_im (num_im_ff),
      .den    (den_ff),
      .done   (div_done),
      .q_re   (q_re),
      .q_im   (q_im)
   );

`ifndef ASSERT_OFF
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished while the sequencer was not waiting");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      load_out |=> out_valid_ff)
      else $error("result register not marked full after a load");
   a_zero_pivot_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_M12 && !item_ff.first_row && prev_zero) |=>
      (state_ff == ST_U0 && zflag_ff))
      else $error("zero pivot did not raise the flag");
`endif
endmodule

// File: sv/tridiagonal_lu_factor_step_top.sv
// Top level of the tridiagonal LU factor step: input queue and row sequencer.
// A first row runs states M0 to M12 and then FIN; a zero pivot row runs U0 to U4 between M12 and FIN,
// and a row that divides also runs DIV_GO and DIV_WAIT before U0, waiting there for the divider.
// Rows are worked one at a time: the shared multiplier and the bit-per-cycle divider serve a single row,
// FIN waits for a free result register, and two rows queue in front while a row is worked on.
// Reset (synchronous, active high) empties both queues and zeroes the stored pivot and Up.
module tridiagonal_lu_factor_step_top #(
   parameter int HALF_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  tlu_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output tlu_pkg::rsp_type rsp_data
);
   import tlu_pkg::*;

   logic    row_valid;
   logic    row_take;
   req_type row_data;

   tlu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .row_valid (row_valid),
      .row_take  (row_take),
      .row_data  (row_data)
   );

   tlu_back #(.HALF_WIDTH(HALF_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .row_valid (row_valid),
      .row_take  (row_take),
      .row_data  (row_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );
endmodule
